/* rtl/pim_pkg.sv */
// ----------------------------------------------------------------------------
// pim_pkg: shared types and constants for the PWM input measurement block
// Field widths, command and phase codes, and the control states.
// ----------------------------------------------------------------------------
package pim_pkg;

  // Field widths
  localparam int TS_W    = 16;          // capture counter width
  localparam int TICK_W  = 24;          // tick rate and frequency width
  localparam int PER_W   = TS_W + 1;    // period = on + off, no wrap
  localparam int DUTY_W  = 7;           // duty in whole percent
  localparam int DIV_W   = TICK_W;      // dividend and quotient width
  localparam int STEPS   = DIV_W;       // one quotient bit per cycle
  localparam int STEP_W  = $clog2(STEPS);

  localparam logic [TICK_W-1:0] TICK_RATE_RESET = TICK_W'(1000000);
  localparam logic [DIV_W-1:0]  PERCENT_SCALE   = DIV_W'(100);

  // Input command codes
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_CAPTURE = 1'b1;

  // Measurement phase: which edge is awaited
  typedef enum logic [1:0] {
    PH_RISE1 = 2'd0,
    PH_FALL  = 2'd1,
    PH_RISE2 = 2'd2,
    PH_IDLE  = 2'd3
  } phase_t;

  // Control sequencer states
  typedef enum logic [1:0] {
    CS_RUN  = 2'd0,   // taking input transactions
    CS_DIV  = 2'd1,   // dividers stepping
    CS_WAIT = 2'd2    // result ready, waiting for the output register
  } ctl_state_t;

  // Divider control and status
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic done;
  } div_sts_t;

endpackage

/* rtl/pim_div.sv */
// ----------------------------------------------------------------------------
// pim_div: bit-serial restoring divider
// Unsigned DIV_W / PER_W division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pim_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pim_pkg::div_ctl_t         ctl,
  input  logic [pim_pkg::DIV_W-1:0] dividend,
  input  logic [pim_pkg::PER_W-1:0] divisor,
  output pim_pkg::div_sts_t         sts,
  output logic [pim_pkg::DIV_W-1:0] quotient
);

  logic [pim_pkg::DIV_W-1:0]  quo_r, quo_nxt;
  logic [pim_pkg::PER_W-1:0]  rem_r, rem_nxt;
  logic [pim_pkg::PER_W-1:0]  dvs_r, dvs_nxt;
  logic [pim_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [pim_pkg::PER_W:0]    trial;
  logic                       fits;

  // Shift the next dividend bit into the partial remainder and try the divisor
  assign trial = {rem_r, quo_r[pim_pkg::DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = pim_pkg::STEP_W'(pim_pkg::STEPS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the top trial bit drops out
      rem_nxt = fits ? pim_pkg::PER_W'(trial - {1'b0, dvs_r})
                     : trial[pim_pkg::PER_W-1:0];
      quo_nxt = {quo_r[pim_pkg::DIV_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

/* rtl/pwm_input_measure.sv */
// ----------------------------------------------------------------------------
// pwm_input_measure: PWM frequency and duty from input-capture timestamps
// Arms on a start command, records rise, fall and second rise, then divides unless the period is zero.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Payload
//  in_      input      in_valid/in_stall  in_command, in_edge_rising, in_timestamp
//  out_     output     out_valid/out_stall out_freq_hz, out_duty_percent,
//                                          out_zero_period
//  cfg_     input      cfg_valid/cfg_ready cfg_data (tick_rate_hz)
//
//  Start commands, the first rising edge and the falling edge are taken without a stall.
//  The closing rising edge starts two bit-serial dividers side by side;
//  once both raise their done flags the result waits for a free output
//  register and is loaded into it, and the next transaction is taken after
//  that load; a zero period skips the dividers and goes straight to the
//  wait for the output register.
//  in_stall is high while dividing and until a result is loaded into the output
//  register; the output register lets one result sit while input continues.
//  Synchronous active-low reset; in_stall is high and cfg_ready low in reset.
// ----------------------------------------------------------------------------
module pwm_input_measure (
  input  logic                       clk,
  input  logic                       rst_n,
  // capture input
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_command,
  input  logic                       in_edge_rising,
  input  logic [pim_pkg::TS_W-1:0]   in_timestamp,
  // result output
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [pim_pkg::TICK_W-1:0] out_freq_hz,
  output logic [pim_pkg::DUTY_W-1:0] out_duty_percent,
  output logic                       out_zero_period,
  // configuration
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pim_pkg::TICK_W-1:0] cfg_data
);

  pim_pkg::ctl_state_t        state_r, state_nxt;
  pim_pkg::phase_t            phase_r, phase_nxt;
  logic [pim_pkg::TS_W-1:0]   rise_r, rise_nxt;
  logic [pim_pkg::TS_W-1:0]   fall_r, fall_nxt;
  logic [pim_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic                       zp_r, zp_nxt;
  logic                       ov_r, ov_nxt;
  logic [pim_pkg::TICK_W-1:0] freq_r, freq_nxt;
  logic [pim_pkg::DUTY_W-1:0] duty_r, duty_nxt;
  logic                       zo_r, zo_nxt;

  logic                       in_accept;
  logic                       third_edge;
  logic                       slot_free;
  logic                       load_out;
  logic [pim_pkg::TS_W-1:0]   on_time, off_time;
  logic [pim_pkg::PER_W-1:0]  period;
  logic                       period_zero;
  logic [pim_pkg::DIV_W-1:0]  on_scaled;
  pim_pkg::div_ctl_t          div_ctl;
  pim_pkg::div_sts_t          sts_f, sts_d;
  logic [pim_pkg::DIV_W-1:0]  quo_f, quo_d;

  assign in_accept = in_valid && !in_stall;
  assign slot_free = !ov_r || !out_stall;

  // Period from stored edges and the closing rising edge
  assign on_time     = fall_r - rise_r;
  assign off_time    = in_timestamp - fall_r;
  assign period      = {1'b0, on_time} + {1'b0, off_time};
  assign period_zero = period == '0;
  assign on_scaled   = pim_pkg::DIV_W'(on_time) * pim_pkg::PERCENT_SCALE;

  // Edge sequencing
  always_comb begin
    phase_nxt  = phase_r;
    rise_nxt   = rise_r;
    fall_nxt   = fall_r;
    third_edge = 1'b0;
    if (in_accept) begin
      if (in_command == pim_pkg::CMD_START) begin
        phase_nxt = pim_pkg::PH_RISE1;
      end else begin
        case (phase_r)
          pim_pkg::PH_RISE1: begin
            if (in_edge_rising) begin
              rise_nxt  = in_timestamp;
              phase_nxt = pim_pkg::PH_FALL;
            end
          end
          pim_pkg::PH_FALL: begin
            if (!in_edge_rising) begin
              fall_nxt  = in_timestamp;
              phase_nxt = pim_pkg::PH_RISE2;
            end
          end
          pim_pkg::PH_RISE2: begin
            if (in_edge_rising) begin
              phase_nxt  = pim_pkg::PH_IDLE;
              third_edge = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pim_pkg::CS_RUN: begin
        if (third_edge) state_nxt = period_zero ? pim_pkg::CS_WAIT : pim_pkg::CS_DIV;
      end
      pim_pkg::CS_DIV: begin
        if (sts_f.done && sts_d.done) state_nxt = pim_pkg::CS_WAIT;
      end
      pim_pkg::CS_WAIT: begin
        if (slot_free) state_nxt = pim_pkg::CS_RUN;
      end
      default: state_nxt = pim_pkg::CS_RUN;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall      = !rst_n || (state_r != pim_pkg::CS_RUN);
    cfg_ready     = rst_n;
    div_ctl.start = third_edge && !period_zero;
    load_out      = (state_r == pim_pkg::CS_WAIT) && slot_free;
  end

  // Zero-period flag, config register and output register
  always_comb begin
    zp_nxt   = zp_r;
    tick_nxt = tick_r;
    ov_nxt   = ov_r;
    freq_nxt = freq_r;
    duty_nxt = duty_r;
    zo_nxt   = zo_r;
    if (third_edge) zp_nxt = period_zero;
    if (cfg_valid && cfg_ready) tick_nxt = cfg_data;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    if (load_out) begin
      ov_nxt   = 1'b1;
      freq_nxt = zp_r ? '0 : quo_f;
      duty_nxt = zp_r ? '0 : quo_d[pim_pkg::DUTY_W-1:0];
      zo_nxt   = zp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pim_pkg::CS_RUN;
      phase_r <= pim_pkg::PH_IDLE;
      rise_r  <= '0;
      fall_r  <= '0;
      tick_r  <= pim_pkg::TICK_RATE_RESET;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      rise_r  <= rise_nxt;
      fall_r  <= fall_nxt;
      tick_r  <= tick_nxt;
      ov_r    <= ov_nxt;
    end
    zp_r   <= zp_nxt;
    freq_r <= freq_nxt;
    duty_r <= duty_nxt;
    zo_r   <= zo_nxt;
  end

  // Frequency: tick rate / period
  pim_div u_div_freq (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (tick_r),
    .divisor  (period),
    .sts      (sts_f),
    .quotient (quo_f)
  );

  // Duty: on time * 100 / period
  pim_div u_div_duty (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (on_scaled),
    .divisor  (period),
    .sts      (sts_d),
    .quotient (quo_d)
  );

  assign out_valid        = ov_r;
  assign out_freq_hz      = freq_r;
  assign out_duty_percent = duty_r;
  assign out_zero_period  = zo_r;

endmodule

/* rtl/pim_checker.sv */
// ----------------------------------------------------------------------------
// pim_checker: port-level checks for the PWM input measurement block
// Watches the result channel against the input channel over time.
// ----------------------------------------------------------------------------
module pim_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] out_freq_hz,
  input logic [6:0]  out_duty_percent,
  input logic        out_zero_period
);

  // A stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_freq_hz)
      && $stable(out_duty_percent) && $stable(out_zero_period))
    else $error("result changed while stalled");

  // Zero period gives zero outputs
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_period |-> out_freq_hz == 24'd0 && out_duty_percent == 7'd0)
    else $error("zero period with non-zero outputs");

  // Duty never exceeds a whole period
  a_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_duty_percent <= 7'd100)
    else $error("duty above 100 percent");

  // A new result only appears after the input side was held off
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a finished measurement");

endmodule

bind pwm_input_measure pim_checker u_pim_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_freq_hz      (out_freq_hz),
  .out_duty_percent (out_duty_percent),
  .out_zero_period  (out_zero_period)
);

/* tb/sv/pwm_input_measure_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_input_measure_test: self-checking bench for the PWM input measurement
// Directed capture sequences from a table, then phases of random
// well-formed rise/fall/rise sequences with stray and broken transactions
// mixed in. Each phase runs with its own tick rate. A local predictor
// works out frequency, duty and the zero-period flag for every completed
// measurement, and each output transaction is checked against it in order.
// ----------------------------------------------------------------------------
module pwm_input_measure_test;

  localparam logic EDGE_RISE = 1'b1;
  localparam logic EDGE_FALL = 1'b0;
  localparam int   SETTLE_CYCLES = 40;   // divider plus hand-over, with margin

  typedef struct packed {
    logic [pim_pkg::TICK_W-1:0] freq_hz;
    logic [pim_pkg::DUTY_W-1:0] duty_percent;
    logic                       zero_period;
  } meas_t;

  typedef struct packed {
    logic                     command;
    logic                     edge_rising;
    logic [pim_pkg::TS_W-1:0] timestamp;
    logic                     known;      // expected measurement written in below
    meas_t                    res;
  } stim_row_t;

  localparam meas_t NO_MEAS = '0;

  // Directed transactions; known rows carry their measurement at 1 MHz ticks
  localparam stim_row_t DIRECTED [27] = '{
    '{pim_pkg::CMD_CAPTURE, EDGE_RISE, 16'h0000, 1'b0, NO_MEAS},  // edge while idle
    '{pim_pkg::CMD_START,   EDGE_FALL, 16'h0000, 1'b0, NO_MEAS},
    '{pim_pkg::CMD_CAPTURE, EDGE_FALL, 16'hFFFF, 1'b0, NO_MEAS},  // wrong polarity
    '{pim_pkg::CMD_CAPTURE, EDGE_RISE, 16'h0000, 1'b0, NO_MEAS},
    '{pim_pkg::CMD_CAPTURE, EDGE_RISE, 16'h0005, 1'b0, NO_MEAS},  // wrong polarity
    '{pim_pkg::CMD_CAPTURE, EDGE_FALL, 16'd250,  1'b0, NO_MEAS},
    '{pim_pkg::CMD_CAPTURE, EDGE_FALL, 16'd300,  1'b0, NO_MEAS},  // wrong polarity
    '{pim_pkg::CMD_CAPTURE, EDGE_RISE, 16'd1000, 1'b1, '{24'd1000, 7'd25, 1'b0}},
    '{pim_pkg::CMD_CAPTURE, EDGE_RISE, 16'd20,   1'b0, NO_MEAS},  // after the result
    '{pim_pkg::CMD_START,   EDGE_RISE, 16'hFFFF, 1'b0, NO_MEAS},
    '{pim_pkg::CMD_CAPTURE, EDGE_RISE, 16'd100,  1'b0, NO_MEAS},
    '{pim_pkg::CMD_CAPTURE, EDGE_FALL, 16'd100,  1'b0, NO_MEAS},
    // zero period
    '{pim_pkg::CMD_CAPTURE, EDGE_RISE, 16'd100,  1'b1, '{24'd0, 7'd0, 1'b1}},
    '{pim_pkg::CMD_START,   EDGE_FALL, 16'h0000, 1'b0, NO_MEAS},
    '{pim_pkg::CMD_CAPTURE, EDGE_RISE, 16'h0000, 1'b0, NO_MEAS},
    '{pim_pkg::CMD_CAPTURE, EDGE_FALL, 16'hFFFF, 1'b0, NO_MEAS},
    // longest period
    '{pim_pkg::CMD_CAPTURE, EDGE_RISE, 16'hFFFE, 1'b1, '{24'd7, 7'd50, 1'b0}},
    '{pim_pkg::CMD_START,   EDGE_RISE, 16'h0000, 1'b0, NO_MEAS},
    '{pim_pkg::CMD_CAPTURE, EDGE_RISE, 16'h1234, 1'b0, NO_MEAS},
    // restart mid-measurement
    '{pim_pkg::CMD_START,   EDGE_FALL, 16'h0000, 1'b0, NO_MEAS},
    '{pim_pkg::CMD_CAPTURE, EDGE_RISE, 16'd5,    1'b0, NO_MEAS},
    '{pim_pkg::CMD_CAPTURE, EDGE_FALL, 16'd5,    1'b0, NO_MEAS},
    '{pim_pkg::CMD_CAPTURE, EDGE_RISE, 16'd9,    1'b1, '{24'd250000, 7'd0, 1'b0}},
    '{pim_pkg::CMD_START,   EDGE_RISE, 16'h0000, 1'b0, NO_MEAS},
    '{pim_pkg::CMD_CAPTURE, EDGE_RISE, 16'd10,   1'b0, NO_MEAS},
    '{pim_pkg::CMD_CAPTURE, EDGE_FALL, 16'd11,   1'b0, NO_MEAS},
    '{pim_pkg::CMD_CAPTURE, EDGE_RISE, 16'd11,   1'b1, '{24'd1000000, 7'd100, 1'b0}}
  };

  // DUT signals
  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic                       in_command = pim_pkg::CMD_START;
  logic                       in_edge_rising = EDGE_FALL;
  logic [pim_pkg::TS_W-1:0]   in_timestamp = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [pim_pkg::TICK_W-1:0] out_freq_hz;
  logic [pim_pkg::DUTY_W-1:0] out_duty_percent;
  logic                       out_zero_period;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [pim_pkg::TICK_W-1:0] cfg_data = '0;

  // Predictor state
  pim_pkg::phase_t            meas_phase = pim_pkg::PH_IDLE;
  logic [pim_pkg::TS_W-1:0]   rise_stamp = '0;
  logic [pim_pkg::TS_W-1:0]   fall_stamp = '0;
  logic [pim_pkg::TICK_W-1:0] tick_rate = pim_pkg::TICK_RATE_RESET;
  meas_t                      expected_meas [$];

  int mismatches = 0;
  int edges_used = 0;
  bit idle_en = 1'b0;
  int stall_left = 0;

  pwm_input_measure uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_edge_rising   (in_edge_rising),
    .in_timestamp     (in_timestamp),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_freq_hz      (out_freq_hz),
    .out_duty_percent (out_duty_percent),
    .out_zero_period  (out_zero_period),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always #10 clk = ~clk;

  // Predict the measurement for one accepted transaction
  task automatic predict_measurement(input logic cmd, input logic rising,
                                     input logic [pim_pkg::TS_W-1:0] stamp,
                                     output bit used);
    logic [pim_pkg::TS_W-1:0]  on_ticks;
    logic [pim_pkg::TS_W-1:0]  off_ticks;
    logic [pim_pkg::PER_W-1:0] period;
    meas_t                     m;
    used = 1'b0;
    if (cmd == pim_pkg::CMD_START) begin
      meas_phase = pim_pkg::PH_RISE1;
      used = 1'b1;
    end else begin
      case (meas_phase)
        pim_pkg::PH_RISE1: if (rising == EDGE_RISE) begin
          rise_stamp = stamp;
          meas_phase = pim_pkg::PH_FALL;
          used = 1'b1;
        end
        pim_pkg::PH_FALL: if (rising == EDGE_FALL) begin
          fall_stamp = stamp;
          meas_phase = pim_pkg::PH_RISE2;
          used = 1'b1;
        end
        pim_pkg::PH_RISE2: if (rising == EDGE_RISE) begin
          meas_phase = pim_pkg::PH_IDLE;
          used = 1'b1;
          on_ticks = fall_stamp - rise_stamp;
          off_ticks = stamp - fall_stamp;
          period = pim_pkg::PER_W'(on_ticks) + pim_pkg::PER_W'(off_ticks);
          if (period == '0) begin
            m = '{freq_hz: '0, duty_percent: '0, zero_period: 1'b1};
          end else begin
            m.freq_hz = pim_pkg::TICK_W'(32'(tick_rate) / 32'(period));
            m.duty_percent = pim_pkg::DUTY_W'(
                (32'(on_ticks) * 32'(pim_pkg::PERCENT_SCALE)) / 32'(period));
            m.zero_period = 1'b0;
          end
          expected_meas.push_back(m);
        end
        default: ;
      endcase
    end
  endtask

  // Offer one input transaction, with an optional gap ahead of it
  task automatic send_capture(input logic cmd, input logic rising,
                              input logic [pim_pkg::TS_W-1:0] stamp);
    bit used;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_edge_rising <= rising;
    in_timestamp   <= stamp;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_measurement(cmd, rising, stamp, used);
    if (used) edges_used++;
  endtask

  // Wait for every expected measurement, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_meas.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tick_rate(input logic [pim_pkg::TICK_W-1:0] rate);
    cfg_valid <= 1'b1;
    cfg_data  <= rate;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    tick_rate = rate;
  endtask

  // Next edge time: equal, close, moderate or anywhere
  function automatic logic [pim_pkg::TS_W-1:0] next_stamp(
      input logic [pim_pkg::TS_W-1:0] base);
    case ($urandom_range(0, 4))
      0:       return base;
      1:       return base + pim_pkg::TS_W'($urandom_range(1, 15));
      2:       return base + pim_pkg::TS_W'($urandom_range(16, 4000));
      default: return pim_pkg::TS_W'($urandom);
    endcase
  endfunction

  // One rise/fall/rise measurement, now and then with a stray transaction
  task automatic send_sequence();
    logic [pim_pkg::TS_W-1:0] t_rise;
    logic [pim_pkg::TS_W-1:0] t_fall;
    logic [pim_pkg::TS_W-1:0] t_next;
    int stray;
    t_rise = pim_pkg::TS_W'($urandom);
    t_fall = next_stamp(t_rise);
    t_next = next_stamp(t_fall);
    stray  = $urandom_range(0, 15);
    send_capture(pim_pkg::CMD_START, 1'($urandom), pim_pkg::TS_W'($urandom));
    if (stray == 0) send_capture(pim_pkg::CMD_CAPTURE, EDGE_FALL, pim_pkg::TS_W'($urandom));
    send_capture(pim_pkg::CMD_CAPTURE, EDGE_RISE, t_rise);
    if (stray == 1) send_capture(pim_pkg::CMD_CAPTURE, EDGE_RISE, pim_pkg::TS_W'($urandom));
    if (stray == 2) begin
      // abandon and restart
      send_capture(pim_pkg::CMD_START, 1'($urandom), pim_pkg::TS_W'($urandom));
      send_capture(pim_pkg::CMD_CAPTURE, EDGE_RISE, t_rise);
    end
    send_capture(pim_pkg::CMD_CAPTURE, EDGE_FALL, t_fall);
    if (stray == 3) send_capture(pim_pkg::CMD_CAPTURE, EDGE_FALL, pim_pkg::TS_W'($urandom));
    send_capture(pim_pkg::CMD_CAPTURE, EDGE_RISE, t_next);
    if (stray == 4) begin
      send_capture(pim_pkg::CMD_CAPTURE, 1'($urandom), pim_pkg::TS_W'($urandom));
    end
  endtask

  // Result side: random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Check each output transaction against the oldest expectation
  always @(posedge clk) begin
    meas_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_meas.size() == 0) begin
        $error("unexpected result: freq_hz %0d duty_percent %0d zero_period %0d",
               out_freq_hz, out_duty_percent, out_zero_period);
        mismatches++;
      end else begin
        want = expected_meas.pop_front();
        if (out_freq_hz !== want.freq_hz) begin
          $error("freq_hz expected %0d got %0d", want.freq_hz, out_freq_hz);
          mismatches++;
        end
        if (out_duty_percent !== want.duty_percent) begin
          $error("duty_percent expected %0d got %0d", want.duty_percent, out_duty_percent);
          mismatches++;
        end
        if (out_zero_period !== want.zero_period) begin
          $error("zero_period expected %0d got %0d", want.zero_period, out_zero_period);
          mismatches++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    logic [pim_pkg::TICK_W-1:0] phase_rates [7];
    int target;
    phase_rates = '{pim_pkg::TICK_W'($urandom_range(1, 16000000)), 24'd1, 24'hFFFFFF,
                    24'd16000000, 24'd0, pim_pkg::TICK_W'($urandom_range(1, 16000000)),
                    pim_pkg::TICK_RATE_RESET};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset tick rate
    idle_en = 1'b1;
    foreach (DIRECTED[i]) begin
      send_capture(DIRECTED[i].command, DIRECTED[i].edge_rising, DIRECTED[i].timestamp);
      if (DIRECTED[i].known) expected_meas[expected_meas.size() - 1] = DIRECTED[i].res;
    end
    drain();

    // Random phases, one tick rate each; the last runs without idling
    edges_used = 0;
    foreach (phase_rates[p]) begin
      write_tick_rate(phase_rates[p]);
      idle_en = (p == 6) ? 1'b0 : ($urandom_range(0, 3) != 0);
      target = edges_used + 270;
      while (edges_used < target) begin
        if ($urandom_range(0, 9) == 0) begin
          send_capture($urandom_range(0, 3) == 0 ? pim_pkg::CMD_START : pim_pkg::CMD_CAPTURE,
                       1'($urandom), pim_pkg::TS_W'($urandom));
        end else begin
          send_sequence();
        end
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #15_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* sim.f */
rtl/pim_pkg.sv
rtl/pim_div.sv
rtl/pwm_input_measure.sv
rtl/pim_checker.sv
tb/sv/pwm_input_measure_test.sv
